/* rtl/gdfs_pkg.sv */
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types and constants for the 3d grid depth-first path finder.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  // largest grid size on each axis, fixed by the 3-bit coordinate fields
  localparam int MAX_DIM = 8;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SOLVE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_LAYERS = 2'd2;

  localparam int unsigned DIRS = 6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wipe_map;     // clear one cell map entry at the sweep counter
    logic write_cell;   // store cell_open from the incoming item
    logic clear_step;   // clear one visited entry at the sweep counter
    logic init_search;  // push start cell if open; found set only if it is the goal
    logic fetch_top;    // read top of stack
    logic try_move;     // evaluate direction at top, issue map reads
    logic commit_move;  // push or pop with map data
    logic read_step;    // read stack entry for a path read
    logic load_result;  // capture result word
  } gdfs_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic search_done;
  } gdfs_status_t;

endpackage

/* rtl/gdfs_if.sv */
// ----------------------------------------------------------------------------
// gdfs_in_if / gdfs_out_if / gdfs_cfg_if
// Valid/ready channels of the path finder.
// ----------------------------------------------------------------------------
interface gdfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] cell_row;
  logic [2:0] cell_col;
  logic [2:0] cell_layer;
  logic       cell_open;
  logic [8:0] step_index;
  modport source (output valid, kind, cell_row, cell_col, cell_layer, cell_open, step_index,
                  input ready);
  modport sink   (input valid, kind, cell_row, cell_col, cell_layer, cell_open, step_index,
                  output ready);
endinterface

interface gdfs_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [9:0] path_length;
  logic [2:0] step_row;
  logic [2:0] step_col;
  logic [2:0] step_layer;
  modport source (output valid, found, path_length, step_row, step_col, step_layer,
                  input ready);
  modport sink   (input valid, found, path_length, step_row, step_col, step_layer,
                  output ready);
endinterface

interface gdfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/grid_3d_dfs_path_finder.sv */
// ----------------------------------------------------------------------------
// grid_3d_dfs_path_finder
// 3d grid depth-first path finder, top level.
// ----------------------------------------------------------------------------
// After reset the block clears its cell map, one cell a cycle, and takes no
// item until that is done. A write item is stored as it is taken. A solve
// first clears the visited map, one cell a cycle, then runs the search; each
// stack step passes through check, fetch top, try direction and commit, and
// each cell is pushed once and tried in 7 steps. A read item reads the stack
// entry and then loads the result.
// One item is handled at a time; the result sits in an output register until
// transferred, and while it waits a solve or read that has finished holds in
// its last cycle and no further item is taken.
module grid_3d_dfs_path_finder
  import gdfs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  gdfs_in_if.sink   in_ch,
  gdfs_out_if.source out_ch,
  gdfs_cfg_if.sink  cfg
);

  gdfs_cmd_t    cmd;
  gdfs_status_t status;
  logic         busy;
  logic         in_fire;
  logic [1:0]   kind_q;
  logic [2:0]   row_q, col_q, lay_q;
  logic         open_q;
  logic [8:0]   idx_q;
  logic [3:0]   rows_in_use, cols_in_use, layers_in_use;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q <= in_ch.kind;
      row_q  <= in_ch.cell_row;
      col_q  <= in_ch.cell_col;
      lay_q  <= in_ch.cell_layer;
      open_q <= in_ch.cell_open;
      idx_q  <= in_ch.step_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= 4'd8;
      cols_in_use   <= 4'd8;
      layers_in_use <= 4'd8;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROWS:   rows_in_use   <= cfg.data;
        REG_COLS:   cols_in_use   <= cfg.data;
        REG_LAYERS: layers_in_use <= cfg.data;
        default:    ;
      endcase
    end
  end

  gdfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .kind(in_ch.kind), .status(status),
    .out_taken(out_ch.ready), .cmd(cmd), .busy(busy), .out_valid(out_ch.valid)
  );

  gdfs_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .kind(cmd.write_cell ? in_ch.kind : kind_q),
    .cell_row(cmd.write_cell ? in_ch.cell_row : row_q),
    .cell_col(cmd.write_cell ? in_ch.cell_col : col_q),
    .cell_layer(cmd.write_cell ? in_ch.cell_layer : lay_q),
    .cell_open(cmd.write_cell ? in_ch.cell_open : open_q),
    .step_index(idx_q),
    .rows_in_use(rows_in_use), .cols_in_use(cols_in_use), .layers_in_use(layers_in_use),
    .found(out_ch.found), .path_length(out_ch.path_length),
    .step_row(out_ch.step_row), .step_col(out_ch.step_col), .step_layer(out_ch.step_layer)
  );

endmodule

/* rtl/gdfs_datapath.sv */
// ----------------------------------------------------------------------------
// gdfs_datapath
// Cell map, visited map, search stack and path read logic.
// ----------------------------------------------------------------------------
module gdfs_datapath
  import gdfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  gdfs_cmd_t            cmd,
  output gdfs_status_t         status,
  input  logic [1:0]           kind,
  input  logic [2:0]           cell_row,
  input  logic [2:0]           cell_col,
  input  logic [2:0]           cell_layer,
  input  logic                 cell_open,
  input  logic [8:0]           step_index,
  input  logic [3:0]           rows_in_use,
  input  logic [3:0]           cols_in_use,
  input  logic [3:0]           layers_in_use,
  output logic                 found,
  output logic [9:0]           path_length,
  output logic [2:0]           step_row,
  output logic [2:0]           step_col,
  output logic [2:0]           step_layer
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = 3 * CW;
  localparam int DW    = AW + 1;

  typedef logic [AW-1:0] addr_t;

  logic             open_mem [CELLS];
  logic             visit_mem[CELLS];
  addr_t            stk_cell [CELLS];
  logic [2:0]       stk_dir  [CELLS];

  logic [DW-1:0]    depth;
  logic             found_flag;
  logic [AW:0]      sweep;
  addr_t            goal;

  // registered top-of-stack and candidate
  addr_t            top_cell;
  logic [2:0]       top_dir;
  addr_t            cand;
  logic             cand_ok;
  logic             open_q;
  logic             visit_q;
  addr_t            step_q;

  logic [CW-1:0]    nr_m1, nc_m1, nl_m1;

  function automatic logic [CW-1:0] ext_m1(input logic [3:0] v);
    logic [4:0] e;
    begin
      e = {1'b0, v};
      if (e == 5'd0) e = 5'd1;
      if (e > 5'(MAX_DIM)) e = 5'(MAX_DIM);
      return CW'(e - 5'd1);
    end
  endfunction

  assign nr_m1 = ext_m1(rows_in_use);
  assign nc_m1 = ext_m1(cols_in_use);
  assign nl_m1 = ext_m1(layers_in_use);

  // address order: layer, row, col
  logic [CW-1:0] tr, tc, tl;
  logic [CW-1:0] mr, mc, ml;
  logic          in_range;

  assign tc = top_cell[CW-1:0];
  assign tr = top_cell[2*CW-1:CW];
  assign tl = top_cell[AW-1:2*CW];

  always_comb begin
    mr = tr;
    mc = tc;
    ml = tl;
    in_range = 1'b0;
    case (top_dir)
      3'd0: begin mr = tr + 1'b1; in_range = tr < nr_m1; end
      3'd1: begin mc = tc + 1'b1; in_range = tc < nc_m1; end
      3'd2: begin ml = tl + 1'b1; in_range = tl < nl_m1; end
      3'd3: begin mr = tr - 1'b1; in_range = tr != '0; end
      3'd4: begin mc = tc - 1'b1; in_range = tc != '0; end
      3'd5: begin ml = tl - 1'b1; in_range = tl != '0; end
      default: in_range = 1'b0;
    endcase
  end

  logic wr_ok;
  assign wr_ok = (cell_row < 3'(MAX_DIM - 1) || cell_row == 3'(MAX_DIM - 1) || MAX_DIM > 8) &&
                 (cell_col < 3'(MAX_DIM - 1) || cell_col == 3'(MAX_DIM - 1) || MAX_DIM > 8) &&
                 (cell_layer < 3'(MAX_DIM - 1) || cell_layer == 3'(MAX_DIM - 1) || MAX_DIM > 8);

  addr_t wr_addr;
  assign wr_addr = {CW'(cell_layer), CW'(cell_row), CW'(cell_col)};

  // open map, wiped by the sweep after reset
  always_ff @(posedge clk) begin
    if (cmd.wipe_map) open_mem[sweep[AW-1:0]] <= 1'b0;
    else if (cmd.write_cell && wr_ok) open_mem[wr_addr] <= cell_open;
    if (cmd.try_move) open_q <= open_mem[{ml, mr, mc}];
  end

  // visited map, cleared by sweep at every solve
  always_ff @(posedge clk) begin
    if (cmd.clear_step) visit_mem[sweep[AW-1:0]] <= 1'b0;
    else if (cmd.init_search) visit_mem['0] <= 1'b1;
    else if (cmd.commit_move && cand_ok && open_q && !visit_q) visit_mem[cand] <= 1'b1;
    if (cmd.try_move) visit_q <= visit_mem[{ml, mr, mc}];
  end

  logic push;
  assign push = cmd.commit_move && cand_ok && open_q && !visit_q;

  logic [2:0] top_dir_rd;
  addr_t      top_cell_rd;
  logic [DW-1:0] top_idx;
  assign top_idx = depth - 1'b1;

  // stack: one write port, one read port
  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      stk_cell[0] <= '0;
      stk_dir[0]  <= 3'd0;
    end else if (push) begin
      stk_cell[depth[AW-1:0]] <= cand;
      stk_dir[depth[AW-1:0]]  <= 3'd0;
    end else if (cmd.try_move) begin
      stk_dir[top_idx[AW-1:0]] <= top_dir + 3'd1;
    end
    if (cmd.read_step) step_q <= stk_cell[step_index[AW-1:0]];
    else if (cmd.fetch_top) begin
      top_cell_rd <= stk_cell[top_idx[AW-1:0]];
      top_dir_rd  <= stk_dir[top_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.try_move) begin
      cand    <= {ml, mr, mc};
      cand_ok <= in_range && top_dir < 3'd6;
    end
  end

  always_comb begin
    top_cell = top_cell_rd;
    top_dir  = top_dir_rd;
  end

  assign goal = {nl_m1, nr_m1, nc_m1};

  logic start_open;
  always_ff @(posedge clk) start_open <= open_mem['0];

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      found_flag <= 1'b0;
      sweep      <= '0;
    end else begin
      if (cmd.clear_step) sweep <= sweep + 1'b1;
      else sweep <= '0;
      if (cmd.init_search) begin
        found_flag <= start_open && goal == '0;
        depth      <= start_open ? DW'(1) : '0;
      end else if (push) begin
        depth <= depth + 1'b1;
        if (cand == goal) found_flag <= 1'b1;
      end else if (cmd.commit_move && top_dir >= 3'd6) begin
        depth <= depth - 1'b1;
      end
    end
  end

  assign status.sweep_done  = sweep == (AW+1)'(CELLS - 1);
  assign status.search_done = found_flag || depth == '0;

  logic [9:0] len;
  assign len = found_flag ? 10'(depth) : 10'd0;

  logic rd_hit;
  always_ff @(posedge clk) begin
    if (cmd.read_step) rd_hit <= kind == KIND_READ && {1'b0, step_index} < len;
    if (cmd.load_result) begin
      found       <= found_flag;
      path_length <= len;
      step_row    <= rd_hit && kind == KIND_READ ? 3'(step_q[2*CW-1:CW]) : 3'd0;
      step_col    <= rd_hit && kind == KIND_READ ? 3'(step_q[CW-1:0]) : 3'd0;
      step_layer  <= rd_hit && kind == KIND_READ ? 3'(step_q[AW-1:2*CW]) : 3'd0;
    end
  end

endmodule

/* rtl/gdfs_ctrl.sv */
// ----------------------------------------------------------------------------
// gdfs_ctrl
// Sequencer for writes, the solve search loop and path reads.
// ----------------------------------------------------------------------------
module gdfs_ctrl
  import gdfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_fire,
  input  logic [1:0]   kind,
  input  gdfs_status_t status,
  input  logic         out_taken,
  output gdfs_cmd_t    cmd,
  output logic         busy,
  output logic         out_valid
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_TRY   = 4'd5;
  localparam logic [3:0] S_COMMIT= 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_LOAD  = 4'd8;
  localparam logic [3:0] S_START = 4'd9;
  localparam logic [3:0] S_WIPE  = 4'd10;

  logic [3:0] state, state_next;
  logic       result_pend;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_WIPE: begin
        cmd.clear_step = 1'b1;
        cmd.wipe_map   = 1'b1;
        if (status.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: if (in_fire) begin
        unique case (kind)
          KIND_WRITE: cmd.write_cell = 1'b1;
          KIND_SOLVE: state_next = S_CLEAR;
          KIND_READ:  state_next = S_READ;
          default:    state_next = S_IDLE;
        endcase
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.sweep_done) state_next = S_START;
      end
      S_START: state_next = S_INIT;
      S_INIT:  begin cmd.init_search = 1'b1; state_next = S_CHECK; end
      S_CHECK: state_next = status.search_done ? S_READ : S_FETCH;
      S_FETCH: begin cmd.fetch_top = 1'b1; state_next = S_TRY; end
      S_TRY:   begin cmd.try_move = 1'b1; state_next = S_COMMIT; end
      S_COMMIT: begin cmd.commit_move = 1'b1; state_next = S_CHECK; end
      S_READ:  begin cmd.read_step = 1'b1; state_next = S_LOAD; end
      // wait here while the previous result still sits in the output register
      S_LOAD:  if (!result_pend || out_taken) begin
        cmd.load_result = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_WIPE;
      result_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) result_pend <= 1'b1;
      else if (out_taken) result_pend <= 1'b0;
    end
  end

  assign out_valid = result_pend;
  assign busy = state != S_IDLE;

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> state == S_IDLE && result_pend)
    else $error("load did not return to idle");
  a_no_fire_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_fire)
    else $error("item taken while busy");
  a_sweep_solve: assert property (@(posedge clk) disable iff (rst)
    cmd.init_search |-> $past(state) == S_START)
    else $error("search started without clear");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the 3d grid depth-first path finder. A directed table covers reset
// state, blocked start and goal, single-cell grids, reads past the end and
// register clamping, then random grids are loaded, solved and read back. Typed
// rows are checked against table values, others against a model of the search.
// ----------------------------------------------------------------------------
module tb_top
  import gdfs_pkg::*;
();

  localparam int DIM       = MAX_DIM;
  localparam int NCELLS    = DIM * DIM * DIM;
  localparam int RAND_ITEMS = 580;
  localparam int STALL_LIMIT = 100000;

  typedef struct packed {
    logic       found;
    logic [9:0] path_length;
    logic [2:0] step_row;
    logic [2:0] step_col;
    logic [2:0] step_layer;
  } route_t;

  typedef struct packed {
    bit         is_cfg;
    logic [1:0] reg_index;
    logic [3:0] reg_data;
    logic [1:0] kind;
    logic [2:0] row;
    logic [2:0] col;
    logic [2:0] layer;
    logic       open;
    logic [8:0] index;
    bit         typed;
    route_t     want;
  } row_t;

  logic clk;
  logic rst;

  gdfs_in_if  in_ch ();
  gdfs_out_if out_ch ();
  gdfs_cfg_if cfg ();

  grid_3d_dfs_path_finder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // local copy of the block state
  bit          grid_open [NCELLS];
  bit          seen      [NCELLS];
  logic [8:0]  trail     [NCELLS];
  logic [2:0]  trail_dir [NCELLS];
  int unsigned trail_depth;
  bit          route_found;
  logic [3:0]  dim_reg [3];

  route_t pending_routes[$];
  row_t   table_rows[$];
  int     mismatches;
  int     quiet_cycles;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_left;

  function automatic void add_route(route_t r);
    pending_routes.insert(pending_routes.size(), r);
  endfunction

  function automatic void add_row(row_t x);
    table_rows.insert(table_rows.size(), x);
  endfunction

  function automatic int clamp_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic int cell_at(int r, int c, int l);
    return (l * DIM + r) * DIM + c;
  endfunction

  task automatic search_grid();
    int nr, nc, nl, goal, here, r, c, l, nxt;
    int dr[6], dc[6], dl[6];
    logic [2:0] d;
    dr = '{1, 0, 0, -1, 0, 0};
    dc = '{0, 1, 0, 0, -1, 0};
    dl = '{0, 0, 1, 0, 0, -1};
    nr = clamp_dim(dim_reg[REG_ROWS]);
    nc = clamp_dim(dim_reg[REG_COLS]);
    nl = clamp_dim(dim_reg[REG_LAYERS]);
    goal = cell_at(nr - 1, nc - 1, nl - 1);
    foreach (seen[i]) seen[i] = 1'b0;
    trail_depth = 0;
    route_found = 1'b0;
    if (!grid_open[0]) return;
    seen[0] = 1'b1;
    trail[0] = '0;
    trail_dir[0] = '0;
    trail_depth = 1;
    if (goal == 0) begin
      route_found = 1'b1;
      return;
    end
    while (trail_depth > 0 && !route_found) begin
      here = int'(trail[trail_depth - 1]);
      d = trail_dir[trail_depth - 1];
      if (d >= DIRS) begin
        trail_depth--;
        continue;
      end
      trail_dir[trail_depth - 1] = d + 3'd1;
      c = here % DIM + dc[d];
      r = (here / DIM) % DIM + dr[d];
      l = here / (DIM * DIM) + dl[d];
      if (r < 0 || r >= nr || c < 0 || c >= nc || l < 0 || l >= nl) continue;
      nxt = cell_at(r, c, l);
      if (!grid_open[nxt] || seen[nxt]) continue;
      seen[nxt] = 1'b1;
      trail[trail_depth] = 9'(nxt);
      trail_dir[trail_depth] = 3'd0;
      trail_depth++;
      if (nxt == goal) route_found = 1'b1;
    end
  endtask

  // update the local state for one accepted item, queue its result if any
  task automatic predict_item(row_t it);
    route_t res;
    int len, spot;
    if (it.kind == KIND_WRITE) begin
      grid_open[cell_at(int'(it.row), int'(it.col), int'(it.layer))] = it.open;
      return;
    end
    if (it.kind != KIND_SOLVE && it.kind != KIND_READ) return;
    if (it.kind == KIND_SOLVE) search_grid();
    len = route_found ? int'(trail_depth) : 0;
    res = '0;
    res.found = route_found;
    res.path_length = 10'(len);
    if (it.kind == KIND_READ && it.index < len) begin
      spot = int'(trail[it.index]);
      res.step_col = 3'(spot % DIM);
      res.step_row = 3'((spot / DIM) % DIM);
      res.step_layer = 3'(spot / (DIM * DIM));
    end
    add_route(it.typed ? it.want : res);
  endtask

  function automatic row_t item(logic [1:0] k, int r, int c, int l, bit o, int idx);
    row_t x;
    x = '0;
    x.kind = k;
    x.row = 3'(r);
    x.col = 3'(c);
    x.layer = 3'(l);
    x.open = o;
    x.index = 9'(idx);
    return x;
  endfunction

  function automatic row_t typed(logic [1:0] k, int idx, bit f, int len,
                                 int sr, int sc, int sl);
    row_t x;
    x = item(k, 0, 0, 0, 0, idx);
    x.typed = 1'b1;
    x.want.found = f;
    x.want.path_length = 10'(len);
    x.want.step_row = 3'(sr);
    x.want.step_col = 3'(sc);
    x.want.step_layer = 3'(sl);
    return x;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, logic [3:0] val);
    row_t x;
    x = '0;
    x.is_cfg = 1'b1;
    x.reg_index = idx;
    x.reg_data = val;
    return x;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(row_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.kind <= it.kind;
    in_ch.cell_row <= it.row;
    in_ch.cell_col <= it.col;
    in_ch.cell_layer <= it.layer;
    in_ch.cell_open <= it.open;
    in_ch.step_index <= it.index;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(it);
  endtask

  // registers change only with the block idle
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    dim_reg[idx] = val;
  endtask

  // result receiver
  initial begin
    out_ch.ready <= 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker
  initial begin
    route_t w;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_routes.size() == 0) begin
          $display("%0t: unexpected result found=%0d len=%0d", $time,
                   out_ch.found, out_ch.path_length);
          mismatches++;
        end else begin
          w = pending_routes.pop_front();
          if (out_ch.found !== w.found || out_ch.path_length !== w.path_length ||
              out_ch.step_row !== w.step_row || out_ch.step_col !== w.step_col ||
              out_ch.step_layer !== w.step_layer) begin
            $display("%0t: mismatch expected f=%0d len=%0d r=%0d c=%0d l=%0d", $time,
                     w.found, w.path_length, w.step_row, w.step_col, w.step_layer);
            $display("%0t:          actual   f=%0d len=%0d r=%0d c=%0d l=%0d", $time,
                     out_ch.found, out_ch.path_length, out_ch.step_row,
                     out_ch.step_col, out_ch.step_layer);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg.valid && cfg.ready) || rst)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t it;
    int sent, nr, nc, nl, nw, nreads, len, t;
    logic [3:0] v;

    mismatches = 0;
    hold_left = 0;
    send_idle_pct = 14;
    recv_idle_pct = 57;
    foreach (grid_open[i]) grid_open[i] = 1'b0;
    trail_depth = 0;
    route_found = 1'b0;
    foreach (dim_reg[i]) dim_reg[i] = 4'd8;
    rst <= 1;
    in_ch.valid <= 0;
    in_ch.kind <= KIND_WRITE;
    in_ch.cell_row <= 0;
    in_ch.cell_col <= 0;
    in_ch.cell_layer <= 0;
    in_ch.cell_open <= 0;
    in_ch.step_index <= 0;
    cfg.valid <= 0;
    cfg.index <= REG_ROWS;
    cfg.data <= 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    add_row(typed(KIND_READ, 0, 0, 0, 0, 0, 0));     // read before solve
    add_row(typed(KIND_SOLVE, 0, 0, 0, 0, 0, 0));    // all walls
    add_row(item(KIND_WRITE, 0, 0, 0, 1, 0));
    add_row(item(KIND_WRITE, 7, 7, 7, 1, 0));
    add_row(typed(KIND_SOLVE, 0, 0, 0, 0, 0, 0));    // goal cut off
    add_row(item(2'd3, 7, 7, 7, 1, 511));            // unused kind
    add_row(reg_row(REG_ROWS, 4'd0));                // zero acts as one
    add_row(reg_row(REG_COLS, 4'd0));
    add_row(reg_row(REG_LAYERS, 4'd1));
    add_row(typed(KIND_SOLVE, 0, 1, 1, 0, 0, 0));    // single cell
    add_row(typed(KIND_READ, 0, 1, 1, 0, 0, 0));
    add_row(typed(KIND_READ, 1, 1, 1, 0, 0, 0));     // past the end
    add_row(typed(KIND_READ, 511, 1, 1, 0, 0, 0));
    add_row(item(KIND_WRITE, 0, 0, 0, 0, 0));
    add_row(typed(KIND_READ, 0, 1, 1, 0, 0, 0));     // path kept
    add_row(typed(KIND_SOLVE, 0, 0, 0, 0, 0, 0));    // start blocked
    add_row(reg_row(REG_ROWS, 4'd2));
    add_row(item(KIND_WRITE, 0, 0, 0, 1, 0));
    add_row(item(KIND_WRITE, 1, 0, 0, 1, 0));
    add_row(typed(KIND_SOLVE, 0, 1, 2, 0, 0, 0));
    add_row(typed(KIND_READ, 1, 1, 2, 1, 0, 0));
    add_row(item(KIND_WRITE, 1, 0, 0, 0, 0));
    add_row(typed(KIND_SOLVE, 0, 0, 0, 0, 0, 0));    // goal blocked
    add_row(reg_row(REG_ROWS, 4'd15));               // clamps to max
    add_row(reg_row(REG_COLS, 4'd8));
    add_row(reg_row(REG_LAYERS, 4'd8));
    add_row(item(KIND_WRITE, 0, 1, 0, 1, 0));
    add_row(item(KIND_WRITE, 0, 0, 0, 1, 0));
    add_row(item(KIND_SOLVE, 0, 0, 0, 0, 0));
    add_row(item(KIND_READ, 0, 0, 0, 0, 1));

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg)
        write_reg(table_rows[i].reg_index, table_rows[i].reg_data);
      else
        send_item(table_rows[i]);
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent >= 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent >= RAND_ITEMS / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 14;
      end

      // new grid extent, mostly small, sometimes full or out of range
      for (int k = 0; k < 3; k++) begin
        t = $urandom_range(99);
        if (t < 5) v = (t < 2) ? 4'd0 : 4'($urandom_range(9, 15));
        else if (t < 15) v = 4'd8;
        else v = 4'($urandom_range(1, 4));
        write_reg(k[1:0], v);
      end
      nr = clamp_dim(dim_reg[REG_ROWS]);
      nc = clamp_dim(dim_reg[REG_COLS]);
      nl = clamp_dim(dim_reg[REG_LAYERS]);

      send_item(item(KIND_WRITE, 0, 0, 0, $urandom_range(99) < 85, 0));
      send_item(item(KIND_WRITE, nr - 1, nc - 1, nl - 1, $urandom_range(99) < 85, 0));
      sent += 2;
      nw = $urandom_range(6, 20);
      repeat (nw) begin
        if ($urandom_range(99) < 90)
          it = item(KIND_WRITE, $urandom_range(nr - 1), $urandom_range(nc - 1),
                    $urandom_range(nl - 1), $urandom_range(99) < 75, $urandom_range(511));
        else
          it = item($urandom_range(99) < 50 ? 2'd3 : KIND_WRITE, $urandom_range(7),
                    $urandom_range(7), $urandom_range(7), $urandom_range(1),
                    $urandom_range(511));
        send_item(it);
        sent++;
      end
      send_item(item(KIND_SOLVE, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                     $urandom_range(1), $urandom_range(511)));
      sent++;

      // the receiver holds off while reads keep coming
      if (hold_left == 0 && sent > RAND_ITEMS / 3 - 40 && sent < RAND_ITEMS / 3)
        hold_left = 400;

      nreads = (hold_left > 0) ? 12 : $urandom_range(2, 6);
      len = route_found ? int'(trail_depth) : 0;
      repeat (nreads) begin
        if (len > 0 && $urandom_range(99) < 80)
          it = item(KIND_READ, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                    $urandom_range(1), $urandom_range(len - 1));
        else
          it = item(KIND_READ, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                    $urandom_range(1), $urandom_range(511));
        send_item(it);
        sent++;
      end
    end

    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_routes.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/gdfs_pkg.sv
rtl/gdfs_if.sv
rtl/gdfs_datapath.sv
rtl/gdfs_ctrl.sv
rtl/grid_3d_dfs_path_finder.sv
bench/tb_top.sv
